/* src/stt_pkg.sv */
// Shared types, constants and character-class helpers for the tokenizer.
// No dependencies.
package stt_pkg;

  localparam int unsigned MaxLineLen = 4096;
  localparam int unsigned LenCapInt = (MaxLineLen < 8191) ? MaxLineLen : 8191;
  localparam logic [12:0] LenCap = 13'(LenCapInt);
  localparam logic [11:0] ColMax = 12'd4095;
  localparam int unsigned NumKw = 10;
  localparam int unsigned QDepth = 4;

  localparam logic [4:0] KindId      = 5'd0;
  localparam logic [4:0] KindNumber  = 5'd1;
  localparam logic [4:0] KindString  = 5'd2;
  localparam logic [4:0] KindKw0     = 5'd3;
  localparam logic [4:0] KindUnknown = 5'd27;

  typedef enum logic [2:0] {
    ModeIdle     = 3'd0,
    ModeIdent    = 3'd1,
    ModeNumber   = 3'd2,
    ModeAfterDot = 3'd3,
    ModeString   = 3'd4
  } mode_e;

  typedef struct packed {
    logic [7:0]  ch;
    logic        end_of_line;
    logic [15:0] line_no;
  } char_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [11:0] start_col;
    logic [12:0] lexeme_len;
    logic [15:0] token_line;
    logic        last_of_run;
  } token_t;

  // Work for the back part: up to two tokens decided by the front part.
  typedef struct packed {
    logic   first_vld;
    logic   second_vld;
    token_t first;
    token_t second;
  } job_t;

  function automatic logic [7:0] kw_char(input int unsigned k, input int unsigned p);
    logic [7:0] c;
    string s;
    case (k)
      0: s = "proclaim";
      1: s = "engrave";
      2: s = "announce";
      3: s = "consider";
      4: s = "otherwise";
      5: s = "whilst";
      6: s = "thou";
      7: s = "shalt";
      8: s = "not";
      default: s = "pass";
    endcase
    c = (p < s.len()) ? s[p] : 8'd0;
    return c;
  endfunction

  function automatic logic [3:0] kw_len(input int unsigned k);
    logic [3:0] l;
    case (k)
      0: l = 4'd8;
      1: l = 4'd7;
      2: l = 4'd8;
      3: l = 4'd8;
      4: l = 4'd9;
      5: l = 4'd6;
      6: l = 4'd4;
      7: l = 4'd5;
      8: l = 4'd3;
      default: l = 4'd4;
    endcase
    return l;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [4:0] symbol_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      "=": k = 5'd13;
      "+": k = 5'd14;
      "-": k = 5'd15;
      "*": k = 5'd16;
      "/": k = 5'd17;
      ";": k = 5'd18;
      "(": k = 5'd19;
      ")": k = 5'd20;
      "{": k = 5'd21;
      "}": k = 5'd22;
      "<": k = 5'd23;
      ">": k = 5'd24;
      "!": k = 5'd25;
      ".": k = 5'd26;
      default: k = KindUnknown;
    endcase
    return k;
  endfunction

endpackage

/* src/stt_if.sv */
// Valid/ready channel interfaces for characters and tokens.
// Depends on stt_pkg.
interface stt_char_if;
  logic           valid;
  logic           ready;
  stt_pkg::char_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface stt_token_if;
  logic            valid;
  logic            ready;
  stt_pkg::token_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/source_text_tokenizer.sv */
// Streaming tokenizer: one character per cycle unless the queue is full, tokens out through a queue.
// A token enters the job queue with the character transfer that ends it.
// Throughput: one character per cycle while the job queue has room; a character ending two tokens
// needs two output transfers, absorbed by the four-entry job queue.
// Reset: asynchronous active low; scanner idle at column zero, queue empty.
module source_text_tokenizer (
  input logic  clk_i,
  input logic  rst_ni,
  stt_char_if.sink    in_ch,
  stt_token_if.source out_tok
);
  import stt_pkg::*;

  logic q_valid, q_ready;
  job_t q_data;

  stt_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_data_i(in_ch.data), .in_ready_o(in_ch.ready),
    .q_ready_i(q_ready), .q_valid_o(q_valid), .q_data_o(q_data)
  );

  stt_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_data_i(q_data), .q_ready_o(q_ready),
    .out_valid_o(out_tok.valid), .out_data_o(out_tok.data), .out_ready_i(out_tok.ready)
  );
endmodule

/* src/stt_front.sv */
// Front part: scans one character per transfer and decides the tokens it ends.
// Depends on stt_pkg.
module stt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  stt_pkg::char_t in_data_i,
  output logic          in_ready_o,
  input  logic          q_ready_i,
  output logic          q_valid_o,
  output stt_pkg::job_t q_data_o
);
  import stt_pkg::*;

  mode_e       mode_q, mode_d;
  logic [11:0] col_q, col_d, start_q, start_d;
  logic [12:0] len_q, len_d;
  logic [NumKw-1:0] cand_q, cand_d;

  logic   fire;
  job_t   job;
  logic [7:0] c, lc;

  assign in_ready_o = q_ready_i;
  assign fire = in_valid_i && q_ready_i;
  assign c = in_data_i.ch;
  assign lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;

  always_comb begin
    logic fresh;
    logic [4:0] kind;
    logic [4:0] sk;
    token_t t;
    mode_d = mode_q;
    col_d = col_q;
    start_d = start_q;
    len_d = len_q;
    cand_d = cand_q;
    fresh = 1'b0;
    job = '0;
    t = '0;
    t.token_line = in_data_i.line_no;
    kind = KindNumber;
    sk = symbol_kind(c);

    case (mode_q)
      ModeIdent: begin
        if (is_letter(c) || is_digit(c) || c == "_") begin
          for (int k = 0; k < NumKw; k++) begin
            if (len_q >= 13'(kw_len(k)) || lc != kw_char(k, int'(len_q[3:0]))) begin
              cand_d[k] = 1'b0;
            end
          end
          if (len_q < LenCap) len_d = len_q + 13'd1;
        end else begin
          fresh = 1'b1;
        end
      end
      ModeNumber: begin
        if (is_digit(c)) begin
          if (len_q < LenCap) len_d = len_q + 13'd1;
        end else if (c == ".") begin
          if (len_q < LenCap) len_d = len_q + 13'd1;
          mode_d = ModeAfterDot;
        end else begin
          fresh = 1'b1;
        end
      end
      ModeAfterDot: begin
        if (is_digit(c)) begin
          if (len_q < LenCap) len_d = len_q + 13'd1;
          mode_d = ModeNumber;
        end else begin
          fresh = 1'b1;
        end
      end
      ModeString: begin
        if (c == "\"") begin
          job.first_vld = 1'b1;
          job.first = t;
          job.first.token_kind = KindString;
          job.first.start_col = start_q;
          job.first.lexeme_len = len_q;
          mode_d = ModeIdle;
        end else if (len_q < LenCap) begin
          len_d = len_q + 13'd1;
        end
      end
      default: fresh = 1'b1;
    endcase

    if (fresh) begin
      if (mode_q == ModeIdent || mode_q == ModeNumber || mode_q == ModeAfterDot) begin
        if (mode_q == ModeIdent) begin
          kind = KindId;
          for (int k = NumKw - 1; k >= 0; k--) begin
            if (cand_q[k] && len_q == 13'(kw_len(k))) kind = KindKw0 + 5'(k);
          end
        end
        job.first_vld = 1'b1;
        job.first = t;
        job.first.token_kind = kind;
        job.first.start_col = start_q;
        job.first.lexeme_len = len_q;
      end
      mode_d = ModeIdle;
      if (c == " ") begin
      end else if (c == "\"") begin
        mode_d = ModeString;
        start_d = (col_q < ColMax) ? col_q + 12'd1 : ColMax;
        len_d = '0;
      end else if (is_letter(c)) begin
        mode_d = ModeIdent;
        start_d = col_q;
        len_d = 13'd1;
        for (int k = 0; k < NumKw; k++) cand_d[k] = (lc == kw_char(k, 0));
      end else if (is_digit(c)) begin
        mode_d = ModeNumber;
        start_d = col_q;
        len_d = 13'd1;
      end else begin
        job.second_vld = 1'b1;
        job.second = t;
        job.second.token_kind = sk;
        job.second.start_col = col_q;
        job.second.lexeme_len = (sk == KindUnknown) ? 13'd0 : 13'd1;
      end
    end

    if (in_data_i.end_of_line) begin
      if (mode_d == ModeIdent || mode_d == ModeNumber || mode_d == ModeAfterDot) begin
        kind = KindNumber;
        if (mode_d == ModeIdent) begin
          kind = KindId;
          for (int k = NumKw - 1; k >= 0; k--) begin
            if (cand_d[k] && len_d == 13'(kw_len(k))) kind = KindKw0 + 5'(k);
          end
        end
        job.second_vld = 1'b1;
        job.second = t;
        job.second.token_kind = kind;
        job.second.start_col = start_d;
        job.second.lexeme_len = len_d;
      end
      mode_d = ModeIdle;
      col_d = '0;
    end else if (col_q < ColMax) begin
      col_d = col_q + 12'd1;
    end

    if (job.second_vld) job.second.last_of_run = 1'b1;
    else job.first.last_of_run = 1'b1;

    if (!fire) begin
      mode_d = mode_q;
      col_d = col_q;
      start_d = start_q;
      len_d = len_q;
      cand_d = cand_q;
    end
  end

  assign q_valid_o = fire && (job.first_vld || job.second_vld);
  assign q_data_o = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      col_q <= '0;
      start_q <= '0;
      len_q <= '0;
      cand_q <= '1;
    end else begin
      mode_q <= mode_d;
      col_q <= col_d;
      start_q <= start_d;
      len_q <= len_d;
      cand_q <= cand_d;
    end
  end
endmodule

/* src/stt_back.sv */
// Back part: job queue and output sequencer that sends one token per transfer.
// Depends on stt_pkg.
module stt_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  stt_pkg::job_t  q_data_i,
  output logic           q_ready_o,
  output logic           out_valid_o,
  output stt_pkg::token_t out_data_o,
  input  logic           out_ready_i
);
  import stt_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);

  job_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic            half_q;
  logic            push, pop, take;
  job_t            head;

  assign head = mem_q[rd_q];
  assign q_ready_o = cnt_q < (PtrW + 1)'(QDepth);
  assign push = q_valid_i && q_ready_o;
  assign out_valid_o = cnt_q != '0;
  assign out_data_o = (head.first_vld && !half_q) ? head.first : head.second;
  assign take = out_valid_o && out_ready_i;
  assign pop = take && (half_q || !head.first_vld || !head.second_vld);

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= q_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
      half_q <= 1'b0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW + 1)'(push) - (PtrW + 1)'(pop);
      if (pop) half_q <= 1'b0;
      else if (take) half_q <= 1'b1;
    end
  end
endmodule

/* src/stt_checker.sv */
// Port-level assertions for the tokenizer, bound to the top level.
// Depends on stt_pkg and the channel interfaces.
module stt_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input stt_pkg::token_t out_data
);
  import stt_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled token changed");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.token_kind <= KindUnknown)
    else $error("token kind out of range");

  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.lexeme_len <= LenCap)
    else $error("lexeme length above cap");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid)
    else $error("token after reset");

  // The input only stalls when the queue is full, so tokens must be waiting.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !in_ready |-> out_valid)
    else $error("input stalled with no token waiting");
endmodule

bind source_text_tokenizer stt_checker u_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_tok.valid), .out_ready(out_tok.ready), .out_data(out_tok.data)
);

/* tb/sv/tb_source_text_tokenizer.sv */
// Self-checking testbench for the streaming source text tokenizer.
// Drives characters through stt_char_if, predicts tokens, checks stt_token_if.
// Depends on stt_pkg, stt_if and source_text_tokenizer.
module tb_source_text_tokenizer;
  import stt_pkg::*;

  logic clk_i;
  logic rst_ni;

  stt_char_if  in_ch ();
  stt_token_if out_tok ();

  source_text_tokenizer dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch.sink),
    .out_tok (out_tok.source)
  );

  char_t  pending_chars[$];
  token_t expected_tokens[$];
  int     errors = 0;
  bit     stim_done = 0;
  int     hold_cycles = 0;
  int     send_gap = 0;
  int     recv_gap = 0;

  mode_e       p_mode;
  logic [11:0] p_col;
  logic [11:0] p_start;
  logic [12:0] p_len;
  logic [9:0]  p_cand;

  string kw_words[10] = '{"proclaim", "engrave", "announce", "consider", "otherwise",
                          "whilst", "thou", "shalt", "not", "pass"};

  function automatic bit letter_c(logic [7:0] c);
    return (c >= 8'd97 && c <= 8'd122) || (c >= 8'd65 && c <= 8'd90);
  endfunction

  function automatic bit digit_c(logic [7:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction

  function automatic logic [4:0] sym_code(logic [7:0] c);
    string syms;
    syms = "=+-*/;(){}<>!.";
    for (int i = 0; i < 14; i++) if (syms[i] == c) return 5'(13 + i);
    return KindUnknown;
  endfunction

  function automatic void push_tok(logic [4:0] k, logic [11:0] s, logic [12:0] l,
                                   logic [15:0] ln);
    token_t t;
    t.token_kind = k;
    t.start_col = s;
    t.lexeme_len = l;
    t.token_line = ln;
    t.last_of_run = 1'b0;
    expected_tokens = {expected_tokens, t};
  endfunction

  function automatic void grow(logic [7:0] c);
    logic [7:0] lc;
    lc = (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
    if (p_mode == ModeIdent)
      for (int k = 0; k < 10; k++)
        if (p_cand[k] && (p_len >= kw_words[k].len() || lc != kw_words[k][p_len]))
          p_cand[k] = 1'b0;
    if (p_len < LenCap) p_len++;
  endfunction

  function automatic void close_word(logic [15:0] ln);
    logic [4:0] k;
    k = KindNumber;
    if (p_mode == ModeIdent) begin
      k = KindId;
      for (int i = 9; i >= 0; i--)
        if (p_cand[i] && p_len == kw_words[i].len()) k = 5'(KindKw0 + i);
    end
    push_tok(k, p_start, p_len, ln);
    p_mode = ModeIdle;
  endfunction

  function automatic void open_token(logic [7:0] c, logic [15:0] ln);
    logic [4:0] k;
    p_mode = ModeIdle;
    if (c == 8'd32) return;
    if (c == 8'd34) begin
      p_mode = ModeString;
      p_start = (p_col < ColMax) ? p_col + 12'd1 : ColMax;
      p_len = 0;
    end else if (letter_c(c)) begin
      p_mode = ModeIdent;
      p_start = p_col;
      p_len = 0;
      p_cand = 10'h3ff;
      grow(c);
    end else if (digit_c(c)) begin
      p_mode = ModeNumber;
      p_start = p_col;
      p_len = 0;
      grow(c);
    end else begin
      k = sym_code(c);
      push_tok(k, p_col, (k == KindUnknown) ? 13'd0 : 13'd1, ln);
    end
  endfunction

  function automatic void predict_tokens(char_t it);
    int n0;
    bit fresh;
    n0 = expected_tokens.size();
    fresh = 0;
    case (p_mode)
      ModeIdent: begin
        if (letter_c(it.ch) || digit_c(it.ch) || it.ch == 8'd95) grow(it.ch);
        else begin
          close_word(it.line_no);
          fresh = 1;
        end
      end
      ModeNumber: begin
        if (digit_c(it.ch)) grow(it.ch);
        else if (it.ch == 8'd46) begin
          grow(it.ch);
          p_mode = ModeAfterDot;
        end else begin
          close_word(it.line_no);
          fresh = 1;
        end
      end
      ModeAfterDot: begin
        if (digit_c(it.ch)) begin
          grow(it.ch);
          p_mode = ModeNumber;
        end else begin
          close_word(it.line_no);
          fresh = 1;
        end
      end
      ModeString: begin
        if (it.ch == 8'd34) begin
          push_tok(KindString, p_start, p_len, it.line_no);
          p_mode = ModeIdle;
        end else grow(it.ch);
      end
      default: fresh = 1;
    endcase
    if (fresh) open_token(it.ch, it.line_no);
    if (it.end_of_line) begin
      if (p_mode == ModeIdent || p_mode == ModeNumber || p_mode == ModeAfterDot)
        close_word(it.line_no);
      p_mode = ModeIdle;
      p_col = 0;
    end else if (p_col < ColMax) p_col++;
    if (expected_tokens.size() > n0)
      expected_tokens[expected_tokens.size() - 1].last_of_run = 1'b1;
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  task automatic add_char(logic [7:0] c, bit eol, logic [15:0] ln);
    char_t it;
    it.ch = c;
    it.end_of_line = eol;
    it.line_no = ln;
    pending_chars = {pending_chars, it};
  endtask

  task automatic add_text(string s, logic [15:0] ln, bit eol_last);
    for (int i = 0; i < s.len(); i++)
      add_char(s[i], eol_last && (i == s.len() - 1), ln);
  endtask

  function automatic logic [7:0] rand_char();
    string pool;
    int r;
    pool = "abzAZ_09.\" =+-*/;(){}<>!.,#";
    r = $urandom_range(0, 9);
    if (r == 0) return 8'($urandom_range(0, 255));
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #50000000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
      send_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_tokens(in_ch.data);
      if (!in_ch.valid || in_ch.ready) begin
        if (in_ch.valid && in_ch.ready) void'(pending_chars.pop_front());
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_chars.size() > ((in_ch.valid && in_ch.ready) ? 0 : 0)) begin
          in_ch.valid <= 1'b1;
          in_ch.data <= pending_chars[0];
          send_gap <= rand_gap();
        end else in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_tok.ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_tok.valid && out_tok.ready) begin
        if (expected_tokens.size() == 0) begin
          $error("token with no expectation: %p", out_tok.data);
          errors++;
        end else begin
          token_t e;
          e = expected_tokens.pop_front();
          if (e.token_kind !== out_tok.data.token_kind) begin
            $error("token_kind exp %0d got %0d", e.token_kind, out_tok.data.token_kind);
            errors++;
          end
          if (e.start_col !== out_tok.data.start_col) begin
            $error("start_col exp %0d got %0d", e.start_col, out_tok.data.start_col);
            errors++;
          end
          if (e.lexeme_len !== out_tok.data.lexeme_len) begin
            $error("lexeme_len exp %0d got %0d", e.lexeme_len, out_tok.data.lexeme_len);
            errors++;
          end
          if (e.token_line !== out_tok.data.token_line) begin
            $error("token_line exp %0d got %0d", e.token_line, out_tok.data.token_line);
            errors++;
          end
          if (e.last_of_run !== out_tok.data.last_of_run) begin
            $error("last_of_run exp %0d got %0d", e.last_of_run,
                   out_tok.data.last_of_run);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_tok.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_tok.ready <= 1'b0;
      end else begin
        out_tok.ready <= 1'b1;
        recv_gap <= rand_gap();
      end
    end
  end

  initial begin
    int line;
    p_mode = ModeIdle;
    p_col = 0;
    p_start = 0;
    p_len = 0;
    p_cand = 10'h3ff;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_tok.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_text("PROCLAIM x1_a 12.5. 3..", 16'd0, 1);
    add_text("\"ab\" \"\" =+-*/;(){}<>!.,", 16'hffff, 0);
    add_char(8'd200, 0, 16'd7);
    add_text("\"open", 16'd8, 1);
    add_text("Engrave announce consider otherwise whilst thou shalt not pass", 16'd9, 1);
    add_text("notx 7", 16'd10, 1);

    hold_cycles = 300;
    line = 11;
    while (pending_chars.size() < 850) begin
      if ($urandom_range(0, 4) != 0) begin
        case ($urandom_range(0, 4))
          0: add_text(kw_words[$urandom_range(0, 9)], 16'(line), 0);
          1: add_text($sformatf("%0d.%0d", $urandom_range(0, 999), $urandom_range(0, 99)),
                      16'(line), 0);
          2: add_text("\"s q\"", 16'(line), 0);
          3: add_text("Ab_9", 16'(line), 0);
          default: add_char(rand_char(), 0, 16'($urandom));
        endcase
        add_char(" ", $urandom_range(0, 5) == 0, 16'(line));
      end else add_char(rand_char(), $urandom_range(0, 6) == 0, 16'($urandom));
      if ($urandom_range(0, 15) == 0) line = $urandom_range(0, 65535);
    end
    add_text(" 1", 16'd5, 1);

    while (pending_chars.size() > 0) @(posedge clk_i);
    @(posedge clk_i);
    while (expected_tokens.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_tokens.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
